FILE: design/ohlc_pkg.sv
// Shared package for the one-minute OHLC bar builder.
// Field widths, default parameter values and the control struct between
// the top level and the bar accumulator. No dependencies.
package ohlc_pkg;

  localparam int unsigned OHLC_PRICE_BITS    = 40;
  localparam int unsigned OHLC_VOLUME_BITS   = 48;
  localparam int unsigned OHLC_TURNOVER_BITS = 62;
  localparam int unsigned OHLC_INTEREST_BITS = 31;
  localparam int unsigned OHLC_HOUR_BITS     = 5;
  localparam int unsigned OHLC_MINUTE_BITS   = 6;
  localparam int unsigned OHLC_DATE_BITS     = 27;

  // Decision for the tick at the head of the pipeline
  typedef struct packed {
    logic fresh;  // tick starts a new bar
    logic emit;   // tick closes the bar in progress
  } ohlc_ctl_t;

endpackage

FILE: design/ohlc_bar_acc.sv
// Bar accumulator: holds the bar in progress and the previous cumulative
// totals, decides whether a tick closes the bar, and updates on advance.
// Depends on ohlc_pkg.
module ohlc_bar_acc #(
  parameter int unsigned PRICE_BITS  = ohlc_pkg::OHLC_PRICE_BITS,
  parameter int unsigned VOLUME_BITS = ohlc_pkg::OHLC_VOLUME_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    advance_i,
  input  logic [ohlc_pkg::OHLC_HOUR_BITS-1:0]     tick_hour_i,
  input  logic [ohlc_pkg::OHLC_MINUTE_BITS-1:0]   tick_minute_i,
  input  logic [PRICE_BITS-1:0]                   last_price_i,
  input  logic [VOLUME_BITS-1:0]                  total_volume_i,
  input  logic [ohlc_pkg::OHLC_TURNOVER_BITS-1:0] total_turnover_i,
  input  logic [ohlc_pkg::OHLC_INTEREST_BITS-1:0] open_interest_i,
  output ohlc_pkg::ohlc_ctl_t                     ctl_o,
  output logic [PRICE_BITS-1:0]                   cur_open_o,
  output logic [PRICE_BITS-1:0]                   cur_high_o,
  output logic [PRICE_BITS-1:0]                   cur_low_o,
  output logic [PRICE_BITS-1:0]                   cur_close_o,
  output logic [VOLUME_BITS-1:0]                  cur_volume_o,
  output logic [ohlc_pkg::OHLC_TURNOVER_BITS-1:0] cur_turnover_o,
  output logic [ohlc_pkg::OHLC_INTEREST_BITS-1:0] cur_interest_o
);
  import ohlc_pkg::*;

  logic                          started_q,   started_d;
  logic [OHLC_HOUR_BITS-1:0]     hour_q,      hour_d;
  logic [OHLC_MINUTE_BITS-1:0]   minute_q,    minute_d;
  logic [PRICE_BITS-1:0]         open_q,      open_d;
  logic [PRICE_BITS-1:0]         high_q,      high_d;
  logic [PRICE_BITS-1:0]         low_q,       low_d;
  logic [PRICE_BITS-1:0]         close_q,     close_d;
  logic [VOLUME_BITS-1:0]        volume_q,    volume_d;
  logic [OHLC_TURNOVER_BITS-1:0] turnover_q,  turnover_d;
  logic [OHLC_INTEREST_BITS-1:0] interest_q,  interest_d;
  logic [VOLUME_BITS-1:0]        prev_vol_q,  prev_vol_d;
  logic [OHLC_TURNOVER_BITS-1:0] prev_turn_q, prev_turn_d;

  logic [VOLUME_BITS:0]          vol_diff;
  logic [OHLC_TURNOVER_BITS:0]   turn_diff;
  logic [VOLUME_BITS-1:0]        dvol;
  logic [OHLC_TURNOVER_BITS-1:0] dturn;
  logic [VOLUME_BITS:0]          vol_sum;
  logic [OHLC_TURNOVER_BITS:0]   turn_sum;
  ohlc_ctl_t                     ctl;

  // Clamp falling totals to a zero delta: borrow out means now < before
  assign vol_diff  = {1'b0, total_volume_i} - {1'b0, prev_vol_q};
  assign turn_diff = {1'b0, total_turnover_i} - {1'b0, prev_turn_q};
  assign dvol      = vol_diff[VOLUME_BITS] ? '0 : vol_diff[VOLUME_BITS-1:0];
  assign dturn     = turn_diff[OHLC_TURNOVER_BITS] ? '0
                                                   : turn_diff[OHLC_TURNOVER_BITS-1:0];

  // Saturate sums: a carry or an all-ones sum both land on all ones
  assign vol_sum  = {1'b0, volume_q} + {1'b0, dvol};
  assign turn_sum = {1'b0, turnover_q} + {1'b0, dturn};

  // Close the bar when hour or minute moves; the first tick only opens one
  assign ctl.emit  = started_q && ((tick_hour_i != hour_q) || (tick_minute_i != minute_q));
  assign ctl.fresh = !started_q || ctl.emit;
  assign ctl_o     = ctl;

  // Next bar state
  always_comb begin
    started_d   = started_q;
    hour_d      = hour_q;
    minute_d    = minute_q;
    open_d      = open_q;
    high_d      = high_q;
    low_d       = low_q;
    close_d     = close_q;
    volume_d    = volume_q;
    turnover_d  = turnover_q;
    interest_d  = interest_q;
    prev_vol_d  = prev_vol_q;
    prev_turn_d = prev_turn_q;
    if (advance_i) begin
      if (ctl.fresh) begin
        started_d  = 1'b1;
        hour_d     = tick_hour_i;
        minute_d   = tick_minute_i;
        open_d     = last_price_i;
        high_d     = last_price_i;
        low_d      = last_price_i;
        volume_d   = dvol;
        turnover_d = dturn;
      end else begin
        if (last_price_i > high_q) begin
          high_d = last_price_i;
        end
        if (last_price_i < low_q) begin
          low_d = last_price_i;
        end
        volume_d   = vol_sum[VOLUME_BITS] ? '1 : vol_sum[VOLUME_BITS-1:0];
        turnover_d = turn_sum[OHLC_TURNOVER_BITS] ? '1
                                                  : turn_sum[OHLC_TURNOVER_BITS-1:0];
      end
      close_d     = last_price_i;
      interest_d  = open_interest_i;
      prev_vol_d  = total_volume_i;
      prev_turn_d = total_turnover_i;
    end
  end

  // Hold the bar in progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      hour_q      <= '0;
      minute_q    <= '0;
      open_q      <= '0;
      high_q      <= '0;
      low_q       <= '0;
      close_q     <= '0;
      volume_q    <= '0;
      turnover_q  <= '0;
      interest_q  <= '0;
      prev_vol_q  <= '0;
      prev_turn_q <= '0;
    end else begin
      started_q   <= started_d;
      hour_q      <= hour_d;
      minute_q    <= minute_d;
      open_q      <= open_d;
      high_q      <= high_d;
      low_q       <= low_d;
      close_q     <= close_d;
      volume_q    <= volume_d;
      turnover_q  <= turnover_d;
      interest_q  <= interest_d;
      prev_vol_q  <= prev_vol_d;
      prev_turn_q <= prev_turn_d;
    end
  end

  assign cur_open_o     = open_q;
  assign cur_high_o     = high_q;
  assign cur_low_o      = low_q;
  assign cur_close_o    = close_q;
  assign cur_volume_o   = volume_q;
  assign cur_turnover_o = turnover_q;
  assign cur_interest_o = interest_q;

  // Once a bar is open the builder never falls back to the unstarted state
  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q) else $error("bar builder lost its started flag");

  // A bar in progress always keeps low <= close <= high and low <= open <= high
  a_range_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> (low_q <= close_q) && (close_q <= high_q) && (low_q <= open_q)
                  && (open_q <= high_q))
    else $error("bar price range out of order");

  // A closing tick can only be seen after a bar was started
  a_emit_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && ctl.emit) |=> started_q) else $error("bar closed before start");

endmodule

FILE: design/one_minute_ohlc_bar_builder_top.sv
// Top level of the one-minute OHLC bar builder: input register, bar
// accumulator and result register with valid/ready on both sides.
// Depends on ohlc_pkg and ohlc_bar_acc.
//
// Usage:
//   Ticks enter on the in_* channel (valid/ready); finished bars leave on
//   the out_* channel (valid/ready). A tick is registered in the input
//   register when transferred, then processed against the bar in progress;
//   a bar it closes is loaded into the result register and shows up on
//   out_valid_o. One tick is taken every cycle while in_ready_o is high; the
//   rate is set by the single input register feeding the bar update.
//   Ticks that stay in the current minute produce nothing. A tick whose hour
//   or minute differs closes the bar; the bar is labelled with that tick's
//   hour, minute and date, and a new bar opens from it. The first tick after
//   reset only opens a bar.
//   Reset clears the bar in progress, the previous totals and both valid
//   flags. When the receiver stalls, ticks that do not close a bar keep
//   flowing; a closing tick waits in the input register while the result
//   register is full, and in_ready_o drops until the bar is transferred.
module one_minute_ohlc_bar_builder_top #(
  parameter int unsigned PRICE_BITS  = ohlc_pkg::OHLC_PRICE_BITS,
  parameter int unsigned VOLUME_BITS = ohlc_pkg::OHLC_VOLUME_BITS
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [ohlc_pkg::OHLC_HOUR_BITS-1:0]     tick_hour_i,
  input  logic [ohlc_pkg::OHLC_MINUTE_BITS-1:0]   tick_minute_i,
  input  logic [ohlc_pkg::OHLC_DATE_BITS-1:0]     tick_date_i,
  input  logic [PRICE_BITS-1:0]                   last_price_i,
  input  logic [VOLUME_BITS-1:0]                  total_volume_i,
  input  logic [ohlc_pkg::OHLC_TURNOVER_BITS-1:0] total_turnover_i,
  input  logic [ohlc_pkg::OHLC_INTEREST_BITS-1:0] open_interest_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [ohlc_pkg::OHLC_HOUR_BITS-1:0]     bar_hour_o,
  output logic [ohlc_pkg::OHLC_MINUTE_BITS-1:0]   bar_minute_o,
  output logic [ohlc_pkg::OHLC_DATE_BITS-1:0]     bar_date_o,
  output logic [PRICE_BITS-1:0]                   open_price_o,
  output logic [PRICE_BITS-1:0]                   high_price_o,
  output logic [PRICE_BITS-1:0]                   low_price_o,
  output logic [PRICE_BITS-1:0]                   close_price_o,
  output logic [VOLUME_BITS-1:0]                  bar_volume_o,
  output logic [ohlc_pkg::OHLC_TURNOVER_BITS-1:0] bar_turnover_o,
  output logic [ohlc_pkg::OHLC_INTEREST_BITS-1:0] bar_open_interest_o
);
  import ohlc_pkg::*;

  // Input register
  logic                          t_vld_q;
  logic [OHLC_HOUR_BITS-1:0]     t_hour_q;
  logic [OHLC_MINUTE_BITS-1:0]   t_minute_q;
  logic [OHLC_DATE_BITS-1:0]     t_date_q;
  logic [PRICE_BITS-1:0]         t_price_q;
  logic [VOLUME_BITS-1:0]        t_vol_q;
  logic [OHLC_TURNOVER_BITS-1:0] t_turn_q;
  logic [OHLC_INTEREST_BITS-1:0] t_oi_q;

  // Result register
  logic                          o_vld_q;
  logic [OHLC_HOUR_BITS-1:0]     o_hour_q;
  logic [OHLC_MINUTE_BITS-1:0]   o_minute_q;
  logic [OHLC_DATE_BITS-1:0]     o_date_q;
  logic [PRICE_BITS-1:0]         o_open_q;
  logic [PRICE_BITS-1:0]         o_high_q;
  logic [PRICE_BITS-1:0]         o_low_q;
  logic [PRICE_BITS-1:0]         o_close_q;
  logic [VOLUME_BITS-1:0]        o_vol_q;
  logic [OHLC_TURNOVER_BITS-1:0] o_turn_q;
  logic [OHLC_INTEREST_BITS-1:0] o_oi_q;

  ohlc_ctl_t                     ctl;
  logic                          advance;
  logic                          in_xfer;
  logic [PRICE_BITS-1:0]         cur_open;
  logic [PRICE_BITS-1:0]         cur_high;
  logic [PRICE_BITS-1:0]         cur_low;
  logic [PRICE_BITS-1:0]         cur_close;
  logic [VOLUME_BITS-1:0]        cur_volume;
  logic [OHLC_TURNOVER_BITS-1:0] cur_turnover;
  logic [OHLC_INTEREST_BITS-1:0] cur_interest;

  // Advance the head tick unless it closes a bar and the result slot is busy
  assign advance    = t_vld_q && (!ctl.emit || !o_vld_q || out_ready_i);
  assign in_ready_o = !t_vld_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  ohlc_bar_acc #(
    .PRICE_BITS  (PRICE_BITS),
    .VOLUME_BITS (VOLUME_BITS)
  ) u_acc (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .tick_hour_i      (t_hour_q),
    .tick_minute_i    (t_minute_q),
    .last_price_i     (t_price_q),
    .total_volume_i   (t_vol_q),
    .total_turnover_i (t_turn_q),
    .open_interest_i  (t_oi_q),
    .ctl_o            (ctl),
    .cur_open_o       (cur_open),
    .cur_high_o       (cur_high),
    .cur_low_o        (cur_low),
    .cur_close_o      (cur_close),
    .cur_volume_o     (cur_volume),
    .cur_turnover_o   (cur_turnover),
    .cur_interest_o   (cur_interest)
  );

  // Track input register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      t_vld_q <= in_valid_i;
    end
  end

  // Capture the tick on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      t_hour_q   <= tick_hour_i;
      t_minute_q <= tick_minute_i;
      t_date_q   <= tick_date_i;
      t_price_q  <= last_price_i;
      t_vol_q    <= total_volume_i;
      t_turn_q   <= total_turnover_i;
      t_oi_q     <= open_interest_i;
    end
  end

  // Track result register occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (advance && ctl.emit) begin
      o_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      o_vld_q <= 1'b0;
    end
  end

  // Load the finished bar, labelled with the closing tick
  always_ff @(posedge clk_i) begin
    if (advance && ctl.emit) begin
      o_hour_q   <= t_hour_q;
      o_minute_q <= t_minute_q;
      o_date_q   <= t_date_q;
      o_open_q   <= cur_open;
      o_high_q   <= cur_high;
      o_low_q    <= cur_low;
      o_close_q  <= cur_close;
      o_vol_q    <= cur_volume;
      o_turn_q   <= cur_turnover;
      o_oi_q     <= cur_interest;
    end
  end

  assign out_valid_o         = o_vld_q;
  assign bar_hour_o          = o_hour_q;
  assign bar_minute_o        = o_minute_q;
  assign bar_date_o          = o_date_q;
  assign open_price_o        = o_open_q;
  assign high_price_o        = o_high_q;
  assign low_price_o         = o_low_q;
  assign close_price_o       = o_close_q;
  assign bar_volume_o        = o_vol_q;
  assign bar_turnover_o      = o_turn_q;
  assign bar_open_interest_o = o_oi_q;

  // Back-pressure only comes from a closing tick meeting a stalled result
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> t_vld_q && ctl.emit && o_vld_q && !out_ready_i)
    else $error("input stalled without a blocked closing tick");

  // A closing tick that advances always fills the result register
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && ctl.emit) |=> o_vld_q) else $error("closed bar not registered");

  // A held tick keeps its contents until it advances
  a_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (t_vld_q && !advance) |=> t_vld_q && $stable(t_hour_q) && $stable(t_minute_q)
                              && $stable(t_price_q))
    else $error("stalled tick changed in the input register");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for one_minute_ohlc_bar_builder_top: directed ticks
// from a table, then random minute-by-minute tick streams with random stalls.
// Depends on ohlc_pkg and the RTL of one_minute_ohlc_bar_builder_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HB = ohlc_pkg::OHLC_HOUR_BITS;
  localparam int MB = ohlc_pkg::OHLC_MINUTE_BITS;
  localparam int DB = ohlc_pkg::OHLC_DATE_BITS;
  localparam int PB = ohlc_pkg::OHLC_PRICE_BITS;
  localparam int VB = ohlc_pkg::OHLC_VOLUME_BITS;
  localparam int TB = ohlc_pkg::OHLC_TURNOVER_BITS;
  localparam int IB = ohlc_pkg::OHLC_INTEREST_BITS;

  localparam logic [PB-1:0] PRICE_MAX    = '1;
  localparam logic [VB-1:0] VOLUME_MAX   = '1;
  localparam logic [TB-1:0] TURNOVER_MAX = '1;
  localparam logic [IB-1:0] INTEREST_MAX = '1;
  localparam logic [DB-1:0] DATE_MAX     = '1;

  localparam int RANDOM_TICKS = 1190;
  localparam int QUIET_TICKS  = 150;
  localparam int PAUSE_AT     = 700;
  localparam int LONG_HOLD_AT = 300;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [HB-1:0] hour;
    logic [MB-1:0] minute;
    logic [DB-1:0] date;
    logic [PB-1:0] price;
    logic [VB-1:0] volume;
    logic [TB-1:0] turnover;
    logic [IB-1:0] interest;
  } tick_t;

  typedef struct packed {
    logic [HB-1:0] hour;
    logic [MB-1:0] minute;
    logic [DB-1:0] date;
    logic [PB-1:0] open_p;
    logic [PB-1:0] high_p;
    logic [PB-1:0] low_p;
    logic [PB-1:0] close_p;
    logic [VB-1:0] volume;
    logic [TB-1:0] turnover;
    logic [IB-1:0] interest;
  } bar_t;

  typedef enum logic {ROW_PREDICT, ROW_TYPED} row_kind_e;

  typedef struct packed {
    tick_t     tick;
    row_kind_e kind;
    bar_t      bar;
  } row_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic [HB-1:0] tick_hour_i;
  logic [MB-1:0] tick_minute_i;
  logic [DB-1:0] tick_date_i;
  logic [PB-1:0] last_price_i;
  logic [VB-1:0] total_volume_i;
  logic [TB-1:0] total_turnover_i;
  logic [IB-1:0] open_interest_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [HB-1:0] bar_hour_o;
  logic [MB-1:0] bar_minute_o;
  logic [DB-1:0] bar_date_o;
  logic [PB-1:0] open_price_o;
  logic [PB-1:0] high_price_o;
  logic [PB-1:0] low_price_o;
  logic [PB-1:0] close_price_o;
  logic [VB-1:0] bar_volume_o;
  logic [TB-1:0] bar_turnover_o;
  logic [IB-1:0] bar_open_interest_o;

  one_minute_ohlc_bar_builder_top u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .tick_hour_i         (tick_hour_i),
    .tick_minute_i       (tick_minute_i),
    .tick_date_i         (tick_date_i),
    .last_price_i        (last_price_i),
    .total_volume_i      (total_volume_i),
    .total_turnover_i    (total_turnover_i),
    .open_interest_i     (open_interest_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .bar_hour_o          (bar_hour_o),
    .bar_minute_o        (bar_minute_o),
    .bar_date_o          (bar_date_o),
    .open_price_o        (open_price_o),
    .high_price_o        (high_price_o),
    .low_price_o         (low_price_o),
    .close_price_o       (close_price_o),
    .bar_volume_o        (bar_volume_o),
    .bar_turnover_o      (bar_turnover_o),
    .bar_open_interest_o (bar_open_interest_o)
  );

  // Bar predictor state
  bit            bar_open;
  bar_t          bar_in_progress;
  logic [VB-1:0] seen_volume;
  logic [TB-1:0] seen_turnover;

  bar_t bars_pending[$];
  int   fail_count;
  int   ticks_sent;
  int   bars_checked;
  bit   quiet;
  bit   held_long;

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b, logic [63:0] limit);
    logic [63:0] s;
    s = a + b;
    return (s >= limit) ? limit : s;
  endfunction

  // Fold one tick into the bar in progress; return 1 when it closes a bar
  function automatic bit advance_bar(input tick_t t, output bar_t done);
    logic [VB-1:0] dv;
    logic [TB-1:0] dt;
    bit            fresh;
    dv = (t.volume > seen_volume) ? t.volume - seen_volume : '0;
    dt = (t.turnover > seen_turnover) ? t.turnover - seen_turnover : '0;
    done        = bar_in_progress;
    done.hour   = t.hour;
    done.minute = t.minute;
    done.date   = t.date;
    fresh = !bar_open || t.hour != bar_in_progress.hour || t.minute != bar_in_progress.minute;
    advance_bar = bar_open && fresh;
    if (fresh) begin
      bar_in_progress.hour     = t.hour;
      bar_in_progress.minute   = t.minute;
      bar_in_progress.open_p   = t.price;
      bar_in_progress.high_p   = t.price;
      bar_in_progress.low_p    = t.price;
      bar_in_progress.volume   = dv;
      bar_in_progress.turnover = dt;
    end else begin
      if (t.price > bar_in_progress.high_p) bar_in_progress.high_p = t.price;
      if (t.price < bar_in_progress.low_p) bar_in_progress.low_p = t.price;
      bar_in_progress.volume   = VB'(sat_sum(64'(bar_in_progress.volume), 64'(dv),
                                             64'(VOLUME_MAX)));
      bar_in_progress.turnover = TB'(sat_sum(64'(bar_in_progress.turnover), 64'(dt),
                                             64'(TURNOVER_MAX)));
    end
    bar_in_progress.close_p  = t.price;
    bar_in_progress.interest = t.interest;
    seen_volume   = t.volume;
    seen_turnover = t.turnover;
    bar_open      = 1'b1;
  endfunction

  function automatic row_t tick_row(logic [HB-1:0] h, logic [MB-1:0] m, logic [DB-1:0] d,
                                    logic [PB-1:0] p, logic [VB-1:0] v, logic [TB-1:0] tu,
                                    logic [IB-1:0] oi);
    row_t r;
    r               = '0;
    r.kind          = ROW_PREDICT;
    r.tick.hour     = h;
    r.tick.minute   = m;
    r.tick.date     = d;
    r.tick.price    = p;
    r.tick.volume   = v;
    r.tick.turnover = tu;
    r.tick.interest = oi;
    return r;
  endfunction

  // Offer one tick at a falling edge and hold it until transferred
  task automatic send_tick(input tick_t t, input row_kind_e kind, input bar_t typed_bar);
    int   gap;
    bar_t predicted;
    bit   closes;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    tick_hour_i      <= t.hour;
    tick_minute_i    <= t.minute;
    tick_date_i      <= t.date;
    last_price_i     <= t.price;
    total_volume_i   <= t.volume;
    total_turnover_i <= t.turnover;
    open_interest_i  <= t.interest;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    closes = advance_bar(t, predicted);
    if (kind == ROW_TYPED) bars_pending.push_back(typed_bar);
    else if (closes) bars_pending.push_back(predicted);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic check_bar(input bar_t exp, input bar_t act);
    if (act.hour != exp.hour) begin
      $error("bar_hour: expected %0d, got %0d", exp.hour, act.hour); fail_count++;
    end
    if (act.minute != exp.minute) begin
      $error("bar_minute: expected %0d, got %0d", exp.minute, act.minute); fail_count++;
    end
    if (act.date != exp.date) begin
      $error("bar_date: expected %0d, got %0d", exp.date, act.date); fail_count++;
    end
    if (act.open_p != exp.open_p) begin
      $error("open_price: expected %0d, got %0d", exp.open_p, act.open_p); fail_count++;
    end
    if (act.high_p != exp.high_p) begin
      $error("high_price: expected %0d, got %0d", exp.high_p, act.high_p); fail_count++;
    end
    if (act.low_p != exp.low_p) begin
      $error("low_price: expected %0d, got %0d", exp.low_p, act.low_p); fail_count++;
    end
    if (act.close_p != exp.close_p) begin
      $error("close_price: expected %0d, got %0d", exp.close_p, act.close_p); fail_count++;
    end
    if (act.volume != exp.volume) begin
      $error("bar_volume: expected %0d, got %0d", exp.volume, act.volume); fail_count++;
    end
    if (act.turnover != exp.turnover) begin
      $error("bar_turnover: expected %0d, got %0d", exp.turnover, act.turnover); fail_count++;
    end
    if (act.interest != exp.interest) begin
      $error("bar_open_interest: expected %0d, got %0d", exp.interest, act.interest);
      fail_count++;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Check each bar transfer against the oldest expectation
  always @(posedge clk_i) begin
    bar_t act;
    if (rst_ni && out_valid_o && out_ready_i) begin
      act = '{bar_hour_o, bar_minute_o, bar_date_o, open_price_o, high_price_o,
              low_price_o, close_price_o, bar_volume_o, bar_turnover_o,
              bar_open_interest_o};
      if (bars_pending.size() == 0) begin
        $error("unexpected bar: hour %0d minute %0d", bar_hour_o, bar_minute_o);
        fail_count++;
      end else begin
        check_bar(bars_pending.pop_front(), act);
        bars_checked++;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    int idle_cycles;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int hold;
    hold        = 0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        hold = 0;
      end else if (!held_long && ticks_sent >= LONG_HOLD_AT) begin
        held_long = 1'b1;
        hold      = LONG_HOLD;
      end else if (hold == 0 && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 10);
      end
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        hold--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Sender: directed table, then random minute streams
  initial begin
    row_t         rows[$];
    row_t         r;
    tick_t        t;
    tick_t        walk;
    logic [223:0] noise;
    int           n;
    int           per_minute;

    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    tick_hour_i      = '0;
    tick_minute_i    = '0;
    tick_date_i      = '0;
    last_price_i     = '0;
    total_volume_i   = '0;
    total_turnover_i = '0;
    open_interest_i  = '0;
    bar_open         = 1'b0;
    bar_in_progress  = '0;
    seen_volume      = '0;
    seen_turnover    = '0;

    // First tick only opens a bar; same-minute ticks set high, low, falling volume
    rows.push_back(tick_row(0, 0, 0, 100, 1000, 5000, 7));
    rows.push_back(tick_row(0, 0, 0, PRICE_MAX, 1500, 5000, 8));
    rows.push_back(tick_row(0, 0, 0, 0, 1200, 6000, 9));
    r = tick_row(0, 1, 20240101, 50, 1300, 6000, 10);
    r.kind = ROW_TYPED;
    r.bar  = bar_t'{0, 1, 20240101, 100, PRICE_MAX, 0, 0, 1500, 6000, 9};
    rows.push_back(r);
    r = tick_row(23, 59, 99991231, PRICE_MAX, VOLUME_MAX, TURNOVER_MAX, INTEREST_MAX);
    r.kind = ROW_TYPED;
    r.bar  = bar_t'{23, 59, 99991231, 50, 50, 50, 50, 100, 0, 10};
    rows.push_back(r);
    // Totals fall to zero, then jump to the top: both sums saturate
    rows.push_back(tick_row(23, 59, 1, 1, 0, 0, 0));
    rows.push_back(tick_row(23, 59, 2, PRICE_MAX, VOLUME_MAX, TURNOVER_MAX, INTEREST_MAX));
    // Out-of-range hour and minute close the bar as given
    r = tick_row(31, 63, DATE_MAX, 5, VOLUME_MAX, TURNOVER_MAX, 3);
    r.kind = ROW_TYPED;
    r.bar  = bar_t'{31, 63, DATE_MAX, PRICE_MAX, PRICE_MAX, 1, PRICE_MAX,
                    VOLUME_MAX, TURNOVER_MAX, INTEREST_MAX};
    rows.push_back(r);
    // Minute-only change, hour-only change, date change within a minute
    rows.push_back(tick_row(31, 0, 20240102, 700, 10, 20, 11));
    rows.push_back(tick_row(0, 0, 20240102, 650, 30, 70, 12));
    rows.push_back(tick_row(0, 0, 20240103, 800, 35, 60, 13));
    rows.push_back(tick_row(0, 1, 20240103, 750, 90, 400, 14));
    rows.push_back(tick_row(0, 1, 20240103, 760, 95, 450, 15));
    rows.push_back(tick_row(12, 30, 20240103, 770, 99, 500, 16));

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) send_tick(rows[i].tick, rows[i].kind, rows[i].bar);

    walk          = '0;
    walk.hour     = HB'($urandom_range(0, 23));
    walk.minute   = MB'($urandom_range(0, 59));
    walk.date     = DB'($urandom_range(20000101, 20991231));
    walk.price    = PB'($urandom_range(1000, 100000));
    walk.volume   = VB'($urandom_range(0, 100000));
    walk.turnover = TB'($urandom_range(0, 1000000));
    walk.interest = IB'($urandom_range(0, 100000));
    n = 0;
    while (n < RANDOM_TICKS) begin
      per_minute = $urandom_range(1, 6);
      repeat (per_minute) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: every field fully random
          noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
          t     = noise[$bits(tick_t)-1:0];
        end else begin
          case ($urandom_range(0, 9))
            0:       walk.price = PB'({$urandom, $urandom});
            1:       walk.price = PRICE_MAX;
            2:       walk.price = '0;
            default: walk.price = walk.price + PB'($urandom_range(0, 200)) - 100;
          endcase
          case ($urandom_range(0, 9))
            0:       walk.volume = walk.volume - VB'($urandom_range(0, 500));
            1:       walk.volume = VOLUME_MAX - VB'($urandom_range(0, 3));
            2:       walk.volume = VB'({$urandom, $urandom});
            default: walk.volume = walk.volume + VB'($urandom_range(0, 5000));
          endcase
          case ($urandom_range(0, 9))
            0:       walk.turnover = walk.turnover - TB'($urandom_range(0, 5000));
            1:       walk.turnover = TURNOVER_MAX - TB'($urandom_range(0, 3));
            2:       walk.turnover = TB'({$urandom, $urandom});
            default: walk.turnover = walk.turnover + TB'($urandom_range(0, 500000));
          endcase
          if ($urandom_range(0, 19) == 0) walk.interest = IB'($urandom);
          else walk.interest = walk.interest + IB'($urandom_range(0, 20)) - 10;
          t = walk;
        end
        if (n >= RANDOM_TICKS - QUIET_TICKS) quiet = 1'b1;
        if (n == PAUSE_AT) begin
          // Pause until every bar in flight has been transferred
          in_valid_i <= 1'b0;
          @(negedge clk_i);
          while (bars_pending.size() != 0) @(negedge clk_i);
        end
        send_tick(t, ROW_PREDICT, '0);
        n++;
      end
      // Advance to the next minute, now and then jump to a random time
      if ($urandom_range(0, 19) == 0) begin
        walk.hour   = HB'($urandom_range(0, 23));
        walk.minute = MB'($urandom_range(0, 59));
        walk.date   = DB'($urandom_range(20000101, 20991231));
      end else if (walk.minute == 59) begin
        walk.minute = 0;
        if (walk.hour == 23) begin
          walk.hour = 0;
          walk.date = walk.date + 1;
        end else begin
          walk.hour = walk.hour + 1;
        end
      end else begin
        walk.minute = walk.minute + 1;
      end
    end
    in_valid_i <= 1'b0;

    // Drain outstanding bars, then watch for strays
    while (bars_pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("summary: %0d ticks sent (table rows, minute streams, noise), %0d bars checked",
             ticks_sent, bars_checked);
    $display("summary: covered saturation, falling totals, out-of-range times and stalls");
    if (fail_count == 0) $display("testbench: PASS");
    else $display("testbench: FAIL");
    $finish;
  end

endmodule
